/* sv/dtq_pkg.sv */
package dtq_pkg;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned DelayW = 32;
  localparam int unsigned TokW   = 32;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned StatW  = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned SlotsDefault = 64;
  // input word: kind, delay, payload, handle, now_time -> 120 bits
  localparam int unsigned InW  = KindW + DelayW + TokW + SlotW + TimeW;
  // output word: status, slot, token -> 41 bits, padded to 48
  localparam int unsigned OutW = 48;

  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [StatW-1:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTPEND  = 3'd3,
    ST_FIRED    = 3'd4,
    ST_NONE_DUE = 3'd5
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic [TokW-1:0]  token;
    logic             last;
  } result_t;
endpackage

/* sv/dtq_scan.sv */
// Sequential scan over the slots: one entry compared per cycle against the
// running best (earliest due deadline, lowest index on ties). The deadline
// store is read with registered data, so each compare runs in the cycle after
// its address goes out.
module dtq_scan #(
  parameter int unsigned Slots = dtq_pkg::SlotsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dtq_pkg::TimeW-1:0] now_i,
  input  logic                      pend_i,     // pending flag of cmp_idx_o
  input  logic [dtq_pkg::TimeW-1:0] dl_i,       // registered deadline of cmp_idx_o
  output logic [dtq_pkg::SlotW-1:0] idx_o,      // read address
  output logic [dtq_pkg::SlotW-1:0] cmp_idx_o,  // index under compare
  output logic                      busy_o,
  output logic                      found_o,
  output logic [dtq_pkg::SlotW-1:0] best_o
);
  import dtq_pkg::*;

  localparam logic [SlotW-1:0] LastIdx = SlotW'(Slots - 1);

  logic [SlotW-1:0] idx_q;
  logic [SlotW-1:0] cmp_idx_q;
  logic             issue_q, cmp_vld_q, found_q;
  logic [SlotW-1:0] best_q;
  logic [TimeW-1:0] bdl_q;
  logic             take;

  // shared compare: due, and strictly earlier than the best so far
  assign take = cmp_vld_q && pend_i && (dl_i <= now_i) && (!found_q || dl_i < bdl_q);

  // address counter and compare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_idx_q <= '0;
      issue_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else if (start_i) begin
      idx_q     <= '0;
      issue_q   <= 1'b1;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      cmp_vld_q <= issue_q;
      cmp_idx_q <= idx_q;
      if (take) found_q <= 1'b1;
      if (issue_q) begin
        if (idx_q == LastIdx) issue_q <= 1'b0;
        else idx_q <= idx_q + 1'b1;
      end
    end
  end

  // running best
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q <= cmp_idx_q;
      bdl_q  <= dl_i;
    end
  end

  assign idx_o     = idx_q;
  assign cmp_idx_o = cmp_idx_q;
  assign busy_o    = issue_q || cmp_vld_q;
  assign found_o   = found_q;
  assign best_o    = best_q;
endmodule

/* sv/deadline_timer_queue.sv */
// Channel | dir | tdata fields (low bit up)                     | tuser
// s_axis  | in  | kind, delay, payload, handle, now_time (120b)  | -
// m_axis  | out | status, slot, token, zero pad (48b)           | - (tlast = last)
// Add: free-slot search, one slot per cycle. Remove: S_REM, then S_OUT, to idle.
// Tick: one scan per fired entry plus one final scan; each fired word is sent
// once the next scan shows whether it is the last. Reset clears the state, time,
// pending flags and output valid, but not the deadline and token stores.
// Output stall holds the sequencer; s_axis_tready is high only when idle.
module deadline_timer_queue #(
  parameter int unsigned SLOTS = dtq_pkg::SlotsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [dtq_pkg::InW-1:0]   s_axis_tdata,  // kind, delay, payload, handle, now_time
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [dtq_pkg::OutW-1:0]  m_axis_tdata,  // status, slot, token
  output logic                      m_axis_tlast
);
  import dtq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_REM  = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q;
  logic [TimeW-1:0]  now_q;
  logic [SLOTS-1:0]  pend_q;
  logic [TimeW-1:0]  dl_mem [SLOTS];
  logic [TokW-1:0]   tok_mem [SLOTS];
  logic [TimeW-1:0]  dl_rd_q;
  logic [TokW-1:0]   tok_rd_q;
  logic              held_q;
  logic [SlotW-1:0]  held_slot_q;
  kind_e             kind;
  logic [DelayW-1:0] in_delay;
  logic [TokW-1:0]   in_pay;
  logic [SlotW-1:0]  in_handle;
  logic [TimeW-1:0]  in_now;
  logic [DelayW-1:0] delay_q;
  logic [TokW-1:0]   pay_q;
  logic [SlotW-1:0]  handle_q;
  logic [SlotW-1:0]  idx_q;
  logic              ovalid_q;
  result_t           res_q;
  logic              scan_start, scan_busy, scan_found, scan_done;
  logic [SlotW-1:0]  scan_idx, scan_cmp_idx, scan_best;
  logic [TimeW:0]    sum;
  logic              in_acc;

  assign kind      = kind_e'(s_axis_tdata[KindW-1:0]);
  assign in_delay  = s_axis_tdata[KindW +: DelayW];
  assign in_pay    = s_axis_tdata[KindW+DelayW +: TokW];
  assign in_handle = s_axis_tdata[KindW+DelayW+TokW +: SlotW];
  assign in_now    = s_axis_tdata[KindW+DelayW+TokW+SlotW +: TimeW];
  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign sum = {1'b0, now_q} + {{(TimeW+1-DelayW){1'b0}}, delay_q};

  dtq_scan #(.Slots(SLOTS)) u_scan (
    .clk_i, .rst_ni,
    .start_i(scan_start), .now_i(now_q),
    .pend_i(pend_q[scan_cmp_idx]), .dl_i(dl_rd_q),
    .idx_o(scan_idx), .cmp_idx_o(scan_cmp_idx), .busy_o(scan_busy),
    .found_o(scan_found), .best_o(scan_best)
  );

  // a finished scan is acted on once the output register is free
  assign scan_done  = (state_q == S_SCAN) && !scan_busy && !ovalid_q;
  assign scan_start = (in_acc && kind == KIND_TICK) || (scan_done && scan_found);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      now_q    <= '0;
      pend_q   <= '0;
      ovalid_q <= 1'b0;
      held_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (kind)
              KIND_ADD:    begin state_q <= S_ADD; idx_q <= '0; end
              KIND_REMOVE: state_q <= S_REM;
              KIND_TICK:   begin
                state_q <= S_SCAN; now_q <= in_now; held_q <= 1'b0;
              end
              default:     state_q <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (!pend_q[idx_q]) begin
            pend_q[idx_q] <= 1'b1;
            ovalid_q <= 1'b1;
            state_q  <= S_OUT;
          end else if (idx_q == SlotW'(SLOTS - 1)) begin
            ovalid_q <= 1'b1;
            state_q  <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_REM: begin
          if ({1'b0, handle_q} < (SlotW+1)'(SLOTS) && pend_q[handle_q])
            pend_q[handle_q] <= 1'b0;
          ovalid_q <= 1'b1;
          state_q  <= S_OUT;
        end
        S_SCAN: begin
          // send the held fired word, or none_due when nothing fired at all
          if (scan_done) begin
            ovalid_q <= held_q || !scan_found;
            if (scan_found) begin
              pend_q[scan_best] <= 1'b0;
              held_q <= 1'b1;
            end else begin
              held_q  <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers, memories and result word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      delay_q  <= in_delay;
      pay_q    <= in_pay;
      handle_q <= in_handle;
    end
    dl_rd_q <= dl_mem[scan_idx];
    if (scan_done && scan_found) begin
      tok_rd_q    <= tok_mem[scan_best];
      held_slot_q <= scan_best;
    end
    unique case (state_q)
      S_ADD: begin
        if (!pend_q[idx_q]) begin
          dl_mem[idx_q]  <= sum[TimeW] ? TimeMax : sum[TimeW-1:0];
          tok_mem[idx_q] <= pay_q;
          res_q <= '{status: ST_ADDED, slot: idx_q, token: '0, last: 1'b1};
        end else if (idx_q == SlotW'(SLOTS - 1)) begin
          res_q <= '{status: ST_FULL, slot: '0, token: '0, last: 1'b1};
        end
      end
      S_REM: begin
        if ({1'b0, handle_q} < (SlotW+1)'(SLOTS) && pend_q[handle_q])
          res_q <= '{status: ST_REMOVED, slot: handle_q, token: '0, last: 1'b1};
        else
          res_q <= '{status: ST_NOTPEND, slot: handle_q, token: '0, last: 1'b1};
      end
      S_SCAN: begin
        // the held word is last when this scan found nothing more
        if (scan_done) begin
          if (held_q)
            res_q <= '{status: ST_FIRED, slot: held_slot_q, token: tok_rd_q,
                       last: !scan_found};
          else if (!scan_found)
            res_q <= '{status: ST_NONE_DUE, slot: '0, token: '0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {{(OutW-StatW-SlotW-TokW){1'b0}}, res_q.token, res_q.slot,
                         res_q.status};
  assign m_axis_tlast = res_q.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !scan_busy) else $error("accept while scanning");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast)) else $error("result word changed while stalled");
endmodule
